// ===== hw/rtl/brl_pkg.sv =====
// Shared types and constants for the line rasterizer.
`default_nettype none

package brl_pkg;

  // Coordinate width kept inside the engine; ports stay at the field width
  localparam int COORD_BITS = 16;
  localparam int FIELD_BITS = 16;
  localparam int ERR_BITS   = COORD_BITS + 1;

  // Depth of the two small queues
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [FIELD_BITS-1:0] SCREEN_WIDTH_RESET  = 16'd480;
  localparam logic [FIELD_BITS-1:0] SCREEN_HEIGHT_RESET = 16'd320;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [FIELD_BITS-1:0] field_t;
  typedef logic [ERR_BITS-1:0]   err_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  // Classified command passed from the front end to the engine
  typedef struct packed {
    op_t    op;
    logic   swapped;
    logic   down;
    coord_t major_start;
    coord_t major_end;
    coord_t minor_start;
    coord_t major_span;
    coord_t minor_span;
    field_t color;
  } cmd_t;

  // One emitted pixel
  typedef struct packed {
    field_t x;
    field_t y;
    field_t color;
    logic   valid;
    logic   done;
  } pix_t;

  // Screen limits for clipping
  typedef struct packed {
    field_t width;
    field_t height;
  } screen_t;

endpackage

`default_nettype wire

// ===== hw/rtl/brl_front.sv =====
// Front end: sorts the endpoints of a start item into major/minor axis form.
`default_nettype none

module brl_front (
  input  wire brl_pkg::op_t   operation,
  input  wire brl_pkg::field_t start_x,
  input  wire brl_pkg::field_t start_y,
  input  wire brl_pkg::field_t end_x,
  input  wire brl_pkg::field_t end_y,
  input  wire brl_pkg::field_t line_color,
  output brl_pkg::cmd_t        cmd
);
  import brl_pkg::*;

  coord_t x1, y1, x2, y2;
  coord_t adx, ady;
  coord_t a1, b1, a2, b2;
  coord_t lo_a, lo_b, hi_a, hi_b;
  logic   steep;

  always_comb begin
    // Reduce endpoints to the coordinate width
    x1 = start_x[COORD_BITS-1:0];
    y1 = start_y[COORD_BITS-1:0];
    x2 = end_x[COORD_BITS-1:0];
    y2 = end_y[COORD_BITS-1:0];

    adx   = (x2 > x1) ? x2 - x1 : x1 - x2;
    ady   = (y2 > y1) ? y2 - y1 : y1 - y2;
    steep = ady > adx;

    // Swap axes for steep lines
    if (steep) begin
      a1 = y1; b1 = x1; a2 = y2; b2 = x2;
    end else begin
      a1 = x1; b1 = y1; a2 = x2; b2 = y2;
    end

    // Order along the major axis
    if (a1 > a2) begin
      lo_a = a2; lo_b = b2; hi_a = a1; hi_b = b1;
    end else begin
      lo_a = a1; lo_b = b1; hi_a = a2; hi_b = b2;
    end

    cmd.op          = operation;
    cmd.swapped     = steep;
    cmd.down        = lo_b > hi_b;
    cmd.major_start = lo_a;
    cmd.major_end   = hi_a;
    cmd.minor_start = lo_b;
    cmd.major_span  = hi_a - lo_a;
    cmd.minor_span  = (hi_b > lo_b) ? hi_b - lo_b : lo_b - hi_b;
    cmd.color       = line_color;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/brl_cmd_queue.sv =====
// Short command queue between the front end and the engine.
`default_nettype none

module brl_cmd_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  wire brl_pkg::cmd_t  push_data,
  output logic                full,
  input  wire                 pop,
  output logic                empty,
  output brl_pkg::cmd_t       head
);
  import brl_pkg::*;

  cmd_t                 entry_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full    = count_r == QCNT_BITS'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign head    = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming command
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/brl_engine.sv =====
// Back end: holds the line state and emits one pixel per command.
`default_nettype none

module brl_engine (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire brl_pkg::screen_t screen,
  input  wire                   cmd_empty,
  input  wire brl_pkg::cmd_t    cmd,
  output logic                  cmd_pop,
  input  wire                   pix_full,
  output logic                  pix_push,
  output brl_pkg::pix_t         pix
);
  import brl_pkg::*;

  logic   active_r, active_nxt;
  logic   swapped_r, down_r;
  coord_t major_r, major_end_r, minor_r, major_span_r, minor_span_r;
  err_t   err_r;
  field_t color_r;

  logic   fire, is_start, cur_active, cur_swapped, cur_down, last, err_neg;
  coord_t cur_major, cur_end, cur_minor, cur_major_span, cur_minor_span;
  coord_t px, py, major_nxt, minor_nxt;
  err_t   cur_err, err_nxt;
  field_t cur_color;
  logic [ERR_BITS:0] err_sub, err_add;

  assign fire     = !cmd_empty && !pix_full;
  assign cmd_pop  = fire;
  assign pix_push = fire;
  assign is_start = cmd.op == OP_START;

  // Select the state this item works on: a start replaces it
  always_comb begin
    cur_active     = is_start || active_r;
    cur_swapped    = is_start ? cmd.swapped     : swapped_r;
    cur_down       = is_start ? cmd.down        : down_r;
    cur_major      = is_start ? cmd.major_start : major_r;
    cur_end        = is_start ? cmd.major_end   : major_end_r;
    cur_minor      = is_start ? cmd.minor_start : minor_r;
    cur_major_span = is_start ? cmd.major_span  : major_span_r;
    cur_minor_span = is_start ? cmd.minor_span  : minor_span_r;
    cur_err        = is_start ? ERR_BITS'(cmd.major_span >> 1) : err_r;
    cur_color      = is_start ? cmd.color       : color_r;
  end

  // Bresenham update: subtract minor span, on underflow move minor and add major span
  always_comb begin
    last      = cur_major == cur_end;
    err_sub   = {cur_err[ERR_BITS-1], cur_err} - {2'b00, cur_minor_span};
    err_neg   = err_sub[ERR_BITS];
    err_add   = err_sub + {2'b00, cur_major_span};
    err_nxt   = err_neg ? err_add[ERR_BITS-1:0] : err_sub[ERR_BITS-1:0];
    minor_nxt = cur_minor;
    if (err_neg) begin
      minor_nxt = cur_down ? cur_minor - 1'b1 : cur_minor + 1'b1;
    end
    major_nxt  = cur_major + 1'b1;
    active_nxt = cur_active && !last;
  end

  // Build the result, swapping the axes back and clipping to the screen
  always_comb begin
    px = cur_swapped ? cur_minor : cur_major;
    py = cur_swapped ? cur_major : cur_minor;
    if (cur_active) begin
      pix.x     = FIELD_BITS'(px);
      pix.y     = FIELD_BITS'(py);
      pix.color = cur_color;
      pix.valid = (FIELD_BITS'(px) < screen.width) && (FIELD_BITS'(py) < screen.height);
      pix.done  = last;
    end else begin
      pix.x     = '0;
      pix.y     = '0;
      pix.color = '0;
      pix.valid = 1'b0;
      pix.done  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (fire) begin
      active_r <= active_nxt;
    end
  end

  // Hold the line state; advance it unless this was the final pixel
  always_ff @(posedge clk) begin
    if (fire && cur_active) begin
      swapped_r    <= cur_swapped;
      down_r       <= cur_down;
      major_end_r  <= cur_end;
      major_span_r <= cur_major_span;
      minor_span_r <= cur_minor_span;
      color_r      <= cur_color;
      if (last) begin
        major_r <= cur_major;
        minor_r <= cur_minor;
        err_r   <= cur_err;
      end else begin
        major_r <= major_nxt;
        minor_r <= minor_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/brl_out_queue.sv =====
// Result queue holding emitted pixels until the consumer takes them.
`default_nettype none

module brl_out_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  wire brl_pkg::pix_t  push_data,
  output logic                full,
  input  wire                 pop,
  output logic                empty,
  output brl_pkg::pix_t       head
);
  import brl_pkg::*;

  pix_t                 entry_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full    = count_r == QCNT_BITS'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign head    = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the emitted pixel
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bresenham_line_rasterizer_core.sv =====
// Top level of the Bresenham line rasterizer with screen clipping.
`default_nettype none

// Push a start item (operation 0) with two endpoints and a colour, then one
// step item (operation 1) per further pixel; every item yields exactly one
// pixel result, with line_done marking the last pixel of the line and
// pixel_valid cleared for pixels outside screen_width x screen_height. A
// step with no line in progress returns a zero pixel with line_done set.
// The block takes one item per cycle while full is low and gives one result
// per cycle while pop is high: the front end sorts the endpoints in the cycle
// an item is pushed, a two-entry command queue decouples it from the engine,
// whose single subtract/add error update per pixel sets the rate, and a
// two-entry result queue holds pixels while pop is low. An accepted item is
// registered in the command queue and its result in the result queue, which
// drives the out_ ports. Screen limits are written through cfg_; the user must
// write them only while the block is idle, as the block does not enforce it.

module bresenham_line_rasterizer_core (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // Item input
  input  wire                                 push,
  output logic                                full,
  input  wire                                 in_operation,
  input  wire [15:0]                          in_start_x,
  input  wire [15:0]                          in_start_y,
  input  wire [15:0]                          in_end_x,
  input  wire [15:0]                          in_end_y,
  input  wire [15:0]                          in_line_color,
  // Pixel output
  output logic                                empty,
  input  wire                                 pop,
  output logic [15:0]                         out_pixel_x,
  output logic [15:0]                         out_pixel_y,
  output logic [15:0]                         out_pixel_color,
  output logic                                out_pixel_valid,
  output logic                                out_line_done,
  // Configuration
  input  wire                                 cfg_we,
  input  wire [brl_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire [15:0]                          cfg_wdata
);
  import brl_pkg::*;

  screen_t screen_r;
  cmd_t    front_cmd, cmd_head;
  pix_t    eng_pix, out_head;
  logic    cmd_empty, cmd_pop, pix_full, pix_push;

  // Screen limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_r.width  <= SCREEN_WIDTH_RESET;
      screen_r.height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_r.width  <= cfg_wdata;
        REG_SCREEN_HEIGHT: screen_r.height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  brl_front u_front (
    .operation  (op_t'(in_operation)),
    .start_x    (in_start_x),
    .start_y    (in_start_y),
    .end_x      (in_end_x),
    .end_y      (in_end_y),
    .line_color (in_line_color),
    .cmd        (front_cmd)
  );

  brl_cmd_queue u_cmd_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_cmd),
    .full      (full),
    .pop       (cmd_pop),
    .empty     (cmd_empty),
    .head      (cmd_head)
  );

  brl_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .screen    (screen_r),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .pix_full  (pix_full),
    .pix_push  (pix_push),
    .pix       (eng_pix)
  );

  brl_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pix_push),
    .push_data (eng_pix),
    .full      (pix_full),
    .pop       (pop),
    .empty     (empty),
    .head      (out_head)
  );

  assign out_pixel_x     = out_head.x;
  assign out_pixel_y     = out_head.y;
  assign out_pixel_color = out_head.color;
  assign out_pixel_valid = out_head.valid;
  assign out_line_done   = out_head.done;

endmodule

`default_nettype wire

// ===== sim/bresenham_line_rasterizer_core_tb.sv =====
// Self-checking testbench for the Bresenham line rasterizer core with screen clipping.
module bresenham_line_rasterizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brl_pkg::*;

  // One line command as pushed into the block
  typedef struct packed {
    op_t    op;
    field_t sx;
    field_t sy;
    field_t ex;
    field_t ey;
    field_t color;
  } line_cmd_t;

  // A command with an optional hand-written expected pixel
  typedef struct packed {
    line_cmd_t cmd;
    logic      typed;
    pix_t      want;
  } line_job_t;

  logic                      clk;
  logic                      rst_n;
  logic                      push;
  logic                      full;
  logic                      in_operation;
  logic [15:0]               in_start_x;
  logic [15:0]               in_start_y;
  logic [15:0]               in_end_x;
  logic [15:0]               in_end_y;
  logic [15:0]               in_line_color;
  logic                      empty;
  logic                      pop;
  logic [15:0]               out_pixel_x;
  logic [15:0]               out_pixel_y;
  logic [15:0]               out_pixel_color;
  logic                      out_pixel_valid;
  logic                      out_line_done;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [15:0]               cfg_wdata;

  bresenham_line_rasterizer_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_operation    (in_operation),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_line_color   (in_line_color),
    .empty           (empty),
    .pop             (pop),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_pixel_valid (out_pixel_valid),
    .out_line_done   (out_line_done),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // Rasterizer state mirrored by the predictor
  field_t                    screen_w = SCREEN_WIDTH_RESET;
  field_t                    screen_h = SCREEN_HEIGHT_RESET;
  logic                      ln_active = 1'b0;
  logic                      ln_swapped = 1'b0;
  coord_t                    maj_pos = '0;
  coord_t                    maj_last = '0;
  coord_t                    min_pos = '0;
  coord_t                    maj_span = '0;
  coord_t                    min_span = '0;
  logic signed [ERR_BITS-1:0] err_acc = '0;
  logic                      min_down = 1'b0;
  field_t                    ln_color = '0;

  line_job_t pending_items[$];
  pix_t      expected_pixels[$];
  int        bad_results = 0;
  int        rx_tick = 0;
  int        rx_mode = 0;

  // Directed lines: corner and clip-edge points, octants, restart mid-line
  line_job_t directed_rows[25] = '{
    '{'{OP_STEP,  16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'hA5A5}, 1'b1,
      '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1}},
    '{'{OP_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF}, 1'b1,
      '{16'h0000, 16'h0000, 16'hFFFF, 1'b1, 1'b1}},
    '{'{OP_STEP,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1}},
    '{'{OP_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000}, 1'b1,
      '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b1}},
    '{'{OP_START, 16'd479,  16'd319,  16'd479,  16'd319,  16'h0F0F}, 1'b1,
      '{16'd479,  16'd319,  16'h0F0F, 1'b1, 1'b1}},
    '{'{OP_START, 16'd480,  16'd319,  16'd480,  16'd319,  16'hF0F0}, 1'b1,
      '{16'd480,  16'd319,  16'hF0F0, 1'b0, 1'b1}},
    '{'{OP_START, 16'd0,    16'd0,    16'd4,    16'd2,    16'h1234}, 1'b0, '0},
    '{'{OP_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{OP_STEP,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
    '{'{OP_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{OP_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{OP_START, 16'd10,   16'd0,    16'd7,    16'd5,    16'hBEEF}, 1'b0, '0},
    '{'{OP_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{OP_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{OP_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{OP_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{OP_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{OP_START, 16'd20,   16'd10,   16'd15,   16'd10,   16'h5555}, 1'b0, '0},
    '{'{OP_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{OP_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{OP_START, 16'd0,    16'hFFFF, 16'd3,    16'hFFFC, 16'hAAAA}, 1'b0, '0},
    '{'{OP_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{OP_START, 16'd476,  16'd318,  16'd484,  16'd322,  16'h7E7E}, 1'b0, '0},
    '{'{OP_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{OP_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit on run time
  initial begin
    #10_000_000;
    $display("bresenham_line_rasterizer_core_tb NOT OK");
    $finish;
  end

  // Work out the pixel one accepted item produces and advance the line state
  function automatic pix_t rasterize_item(input line_cmd_t cmd);
    pix_t   px;
    coord_t a1;
    coord_t b1;
    coord_t a2;
    coord_t b2;
    coord_t tmp;
    coord_t adx;
    coord_t ady;
    px = '0;
    if (cmd.op == OP_START) begin
      adx = (cmd.ex > cmd.sx) ? cmd.ex - cmd.sx : cmd.sx - cmd.ex;
      ady = (cmd.ey > cmd.sy) ? cmd.ey - cmd.sy : cmd.sy - cmd.ey;
      ln_swapped = (ady > adx);
      if (ln_swapped) begin
        a1 = cmd.sy; b1 = cmd.sx; a2 = cmd.ey; b2 = cmd.ex;
      end else begin
        a1 = cmd.sx; b1 = cmd.sy; a2 = cmd.ex; b2 = cmd.ey;
      end
      // order the endpoints along the major axis
      if (a1 > a2) begin
        tmp = a1; a1 = a2; a2 = tmp;
        tmp = b1; b1 = b2; b2 = tmp;
      end
      maj_pos   = a1;
      maj_last  = a2;
      min_pos   = b1;
      maj_span  = a2 - a1;
      min_span  = (b2 > b1) ? b2 - b1 : b1 - b2;
      min_down  = (b1 > b2);
      err_acc   = $signed({2'b00, maj_span[COORD_BITS-1:1]});
      ln_color  = cmd.color;
      ln_active = 1'b1;
    end else if (!ln_active) begin
      px.done = 1'b1;
      return px;
    end
    // emit the current pixel with axes restored
    px.x     = ln_swapped ? min_pos : maj_pos;
    px.y     = ln_swapped ? maj_pos : min_pos;
    px.color = ln_color;
    px.valid = (px.x < screen_w) && (px.y < screen_h);
    px.done  = (maj_pos == maj_last);
    if (px.done) begin
      ln_active = 1'b0;
      return px;
    end
    err_acc = err_acc - $signed({1'b0, min_span});
    if (err_acc < 0) begin
      min_pos = min_down ? min_pos - 1'b1 : min_pos + 1'b1;
      err_acc = err_acc + $signed({1'b0, maj_span});
    end
    maj_pos = maj_pos + 1'b1;
    return px;
  endfunction

  // Coordinate biased towards the clip edge, the origin, or anywhere
  function automatic field_t pick_coord(input field_t limit);
    case ($urandom_range(0, 3))
      0, 1:    return field_t'(int'(limit) + int'($urandom_range(0, 32)) - 16);
      2:       return field_t'($urandom_range(0, 65535));
      default: return field_t'($urandom_range(0, 63));
    endcase
  endfunction

  // Queue random lines: mostly whole lines, some cut short or overrun, some noise
  task automatic queue_random_lines(input int n_items);
    line_job_t job;
    int        count;
    int        kind;
    int        reach;
    int        steps;
    coord_t    adx;
    coord_t    ady;
    count = 0;
    while (count < n_items) begin
      job = '0;
      kind = $urandom_range(0, 15);
      job.cmd.color = field_t'($urandom_range(0, 65535));
      if (kind == 0) begin
        // lone item of either kind with random fields
        job.cmd.op = $urandom_range(0, 1) ? OP_STEP : OP_START;
        job.cmd.sx = field_t'($urandom_range(0, 65535));
        job.cmd.sy = field_t'($urandom_range(0, 65535));
        job.cmd.ex = field_t'($urandom_range(0, 65535));
        job.cmd.ey = field_t'($urandom_range(0, 65535));
        pending_items.push_back(job);
        count++;
        continue;
      end
      job.cmd.op = OP_START;
      if (kind == 1) begin
        job.cmd.sx = field_t'($urandom_range(0, 65535));
        job.cmd.sy = field_t'($urandom_range(0, 65535));
        job.cmd.ex = field_t'($urandom_range(0, 65535));
        job.cmd.ey = field_t'($urandom_range(0, 65535));
      end else begin
        reach = ($urandom_range(0, 3) == 0) ? 3 : 20;
        job.cmd.sx = pick_coord(screen_w);
        job.cmd.sy = pick_coord(screen_h);
        job.cmd.ex = field_t'(int'(job.cmd.sx) + int'($urandom_range(0, 2 * reach)) - reach);
        job.cmd.ey = field_t'(int'(job.cmd.sy) + int'($urandom_range(0, 2 * reach)) - reach);
      end
      pending_items.push_back(job);
      count++;
      adx = (job.cmd.ex > job.cmd.sx) ? job.cmd.ex - job.cmd.sx : job.cmd.sx - job.cmd.ex;
      ady = (job.cmd.ey > job.cmd.sy) ? job.cmd.ey - job.cmd.sy : job.cmd.sy - job.cmd.ey;
      steps = (adx > ady) ? int'(adx) : int'(ady);
      if (steps > 48) steps = $urandom_range(0, 16);
      else if ($urandom_range(0, 7) == 0) steps = $urandom_range(0, steps);
      else if ($urandom_range(0, 7) == 0) steps = steps + $urandom_range(1, 3);
      // step items carry junk in the ignored fields
      repeat (steps) begin
        job.cmd.op = OP_STEP;
        job.cmd.sx = field_t'($urandom_range(0, 65535));
        job.cmd.sy = field_t'($urandom_range(0, 65535));
        job.cmd.ex = field_t'($urandom_range(0, 65535));
        job.cmd.ey = field_t'($urandom_range(0, 65535));
        job.cmd.color = field_t'($urandom_range(0, 65535));
        pending_items.push_back(job);
        count++;
      end
    end
  endtask

  // Send queued items in bursts with random gaps; record expectations on transfer
  task automatic play_pending();
    line_job_t job;
    pix_t      want;
    int        burst;
    int        gap;
    while (pending_items.size() > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && pending_items.size() > 0) begin
        job = pending_items.pop_front();
        in_operation  <= job.cmd.op;
        in_start_x    <= job.cmd.sx;
        in_start_y    <= job.cmd.sy;
        in_end_x      <= job.cmd.ex;
        in_end_y      <= job.cmd.ey;
        in_line_color <= job.cmd.color;
        push          <= 1'b1;
        do @(posedge clk); while (full);
        want = rasterize_item(job.cmd);
        if (job.typed) want = job.want;
        expected_pixels.push_back(want);
        burst--;
      end
      case ($urandom_range(0, 7))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(20, 40);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    push <= 1'b0;
  endtask

  // Hold off until every expected pixel has been taken, then let the block settle
  task automatic wait_for_drain();
    while (expected_pixels.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both screen limits while the block is idle
  task automatic set_screen(input field_t w, input field_t h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we   <= 1'b0;
    screen_w = w;
    screen_h = h;
  endtask

  // Check each pixel transfer against the oldest expectation; drive pop stalls
  always @(posedge clk) begin
    pix_t want;
    if (rst_n && pop && !empty) begin
      if (expected_pixels.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected pixel x=%h y=%h c=%h v=%b d=%b", out_pixel_x,
                   out_pixel_y, out_pixel_color, out_pixel_valid, out_line_done);
      end else begin
        want = expected_pixels.pop_front();
        if (out_pixel_x !== want.x || out_pixel_y !== want.y ||
            out_pixel_color !== want.color || out_pixel_valid !== want.valid ||
            out_line_done !== want.done) begin
          bad_results++;
          if (bad_results <= 10)
            $display({"pixel mismatch: exp x=%h y=%h c=%h v=%b d=%b, ",
                      "got x=%h y=%h c=%h v=%b d=%b"},
                     want.x, want.y, want.color, want.valid, want.done, out_pixel_x,
                     out_pixel_y, out_pixel_color, out_pixel_valid, out_line_done);
        end
      end
    end
    // receiver stall pattern in one of four randomly chosen modes
    rx_tick <= rx_tick + 1;
    if (rx_tick % 64 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0:       pop <= 1'b1;
      1:       pop <= $urandom_range(0, 1);
      2:       pop <= ($urandom_range(0, 3) == 0);
      default: pop <= rx_tick[2];
    endcase
  end

  // Main sequence: reset, directed lines, then random phases over several screen sizes
  initial begin
    int     p;
    field_t pw[6];
    field_t ph[6];
    rst_n         <= 1'b0;
    push          <= 1'b0;
    in_operation  <= OP_START;
    in_start_x    <= '0;
    in_start_y    <= '0;
    in_end_x      <= '0;
    in_end_y      <= '0;
    in_line_color <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_SCREEN_WIDTH;
    cfg_wdata     <= '0;
    pw = '{SCREEN_WIDTH_RESET, 16'hFFFF, 16'h0000, 16'd100, 16'h0000, 16'd1};
    ph = '{SCREEN_HEIGHT_RESET, 16'hFFFF, 16'h0000, 16'd60, 16'h0000, 16'hFFFF};
    pw[4] = field_t'($urandom_range(0, 65535));
    ph[4] = field_t'($urandom_range(0, 65535));
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) pending_items.push_back(directed_rows[i]);
    play_pending();

    for (p = 0; p < 6; p++) begin
      wait_for_drain();
      if (p > 0) set_screen(pw[p], ph[p]);
      queue_random_lines(290);
      play_pending();
    end

    wait_for_drain();
    repeat (8) @(posedge clk);
    if (bad_results == 0 && expected_pixels.size() == 0)
      $display("bresenham_line_rasterizer_core_tb OK");
    else
      $display("bresenham_line_rasterizer_core_tb NOT OK");
    $finish;
  end

endmodule
